// File: rtl/core/fravg_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate meter package
// Shared widths, constants and the sequencer state type of the frame rate
// meter with moving average.
// ----------------------------------------------------------------------------
package fravg_pkg;

  // Number of rate entries kept in the averaging window.
  localparam int HISTORY_DEPTH = 512;

  // Payload field widths.
  localparam int TIME_W = 32;
  localparam int DIM_W  = 12;
  localparam int RATE_W = 18;
  localparam int AVG_W  = 10;

  // Derived widths for the window bookkeeping.
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = RATE_W + CNT_W;

  // Bit-serial divider step counter.
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // Rate numerator (256 * 1000 ms) and saturation limits.
  localparam int RATE_NUM = 256000;
  localparam int RATE_MAX = (1 << RATE_W) - 1;
  localparam int AVG_MAX  = (1 << AVG_W) - 1;

  // Fraction bits of the Q10.8 rate.
  localparam int FRAC_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_UPDATE,
    ST_AVG_DIV,
    ST_DONE
  } fravg_state_t;

endpackage

// File: rtl/core/fravg_in_if.sv
// ----------------------------------------------------------------------------
// Frame event channel
// Valid/ready channel that carries one frame event per beat.
// ----------------------------------------------------------------------------
interface fravg_in_if;
  logic                         valid;
  logic                         ready;
  logic [fravg_pkg::TIME_W-1:0] now_ms;
  logic                         frame_is_null;
  logic [fravg_pkg::DIM_W-1:0]  frame_width;
  logic [fravg_pkg::DIM_W-1:0]  frame_height;

  modport source (output valid, now_ms, frame_is_null, frame_width, frame_height,
                  input ready);
  modport sink   (input valid, now_ms, frame_is_null, frame_width, frame_height,
                  output ready);
endinterface

// File: rtl/core/fravg_out_if.sv
// ----------------------------------------------------------------------------
// Frame rate result channel
// Valid/ready channel that carries one rate measurement per beat.
// ----------------------------------------------------------------------------
interface fravg_out_if;
  logic                         valid;
  logic                         ready;
  logic [fravg_pkg::RATE_W-1:0] fps_instant;
  logic [fravg_pkg::AVG_W-1:0]  fps_average;
  logic [fravg_pkg::DIM_W-1:0]  held_width;
  logic [fravg_pkg::DIM_W-1:0]  held_height;

  modport source (output valid, fps_instant, fps_average, held_width, held_height,
                  input ready);
  modport sink   (input valid, fps_instant, fps_average, held_width, held_height,
                  output ready);
endinterface

// File: rtl/core/frame_rate_moving_average_top.sv
// Sequence: an accepted frame beat runs the rate division, the window update and
//   the mean division, then loads the result once the output is free.
// New frames wait until the result is loaded; the one-bit-per-cycle divider
//   (SUM_W = 28 at the default window of 512 entries) forms rate, then mean.
// Reset: synchronous, active low; clears the time, count, sum, slot and size holds.
//   The history memory is not cleared; an entry is only used after it was written.
// ----------------------------------------------------------------------------
// Frame rate meter with moving average
// Measures the interval between frame beats, converts it to a Q10.8 rate and
// keeps a windowed running mean of the rates in a history memory.
// ----------------------------------------------------------------------------
module frame_rate_moving_average_top (
  input  logic          clk,
  input  logic          rst_n,
  fravg_in_if.sink      in_ch,
  fravg_out_if.source   out_ch
);

  // Control state.
  fravg_pkg::fravg_state_t              state_r, state_nxt;
  logic [fravg_pkg::TIME_W-1:0]         last_time_r;
  logic [fravg_pkg::SLOT_W-1:0]         slot_r;
  logic [fravg_pkg::CNT_W-1:0]          cnt_r;
  logic [fravg_pkg::SUM_W-1:0]          sum_r;
  logic [fravg_pkg::DIM_W-1:0]          width_hold_r;
  logic [fravg_pkg::DIM_W-1:0]          height_hold_r;
  logic                                 out_valid_r;

  // Datapath registers.
  logic [fravg_pkg::RATE_W-1:0]         hist_mem [fravg_pkg::HISTORY_DEPTH];
  logic [fravg_pkg::RATE_W-1:0]         rd_data_r;
  logic [fravg_pkg::RATE_W-1:0]         rate_r;
  logic                                 zero_int_r;
  logic [fravg_pkg::SUM_W-1:0]          dvd_r;
  logic [fravg_pkg::TIME_W-1:0]         dvs_r;
  logic [fravg_pkg::TIME_W-1:0]         rem_r;
  logic [fravg_pkg::DIV_CNT_W-1:0]      div_cnt_r;

  logic [fravg_pkg::RATE_W-1:0]         fps_instant_r;
  logic [fravg_pkg::AVG_W-1:0]          fps_average_r;
  logic [fravg_pkg::DIM_W-1:0]          held_width_r;
  logic [fravg_pkg::DIM_W-1:0]          held_height_r;

  // Combinational signals.
  logic                                 in_accept;
  logic                                 out_free;
  logic                                 out_load;
  logic                                 div_step;
  logic                                 div_last;
  logic                                 win_full;
  logic [fravg_pkg::TIME_W-1:0]         interval;
  logic [fravg_pkg::TIME_W:0]           rem_shift;
  logic                                 q_bit;
  logic [fravg_pkg::TIME_W-1:0]         rem_nxt;
  logic [fravg_pkg::RATE_W-1:0]         rate_val;
  logic [fravg_pkg::SUM_W-1:0]          sum_nxt;
  logic [fravg_pkg::CNT_W-1:0]          cnt_nxt;
  logic [fravg_pkg::SLOT_W-1:0]         slot_nxt;
  logic [fravg_pkg::SUM_W-fravg_pkg::FRAC_W-1:0] avg_full;
  logic [fravg_pkg::AVG_W-1:0]          avg_val;

  // Handshake qualifiers.
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign div_last  = (div_cnt_r == '0);
  assign win_full  = (cnt_r == fravg_pkg::CNT_W'(fravg_pkg::HISTORY_DEPTH));
  assign interval  = in_ch.now_ms - last_time_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fravg_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = fravg_pkg::ST_RATE_DIV;
      end
      fravg_pkg::ST_RATE_DIV: begin
        if (div_last) state_nxt = fravg_pkg::ST_UPDATE;
      end
      fravg_pkg::ST_UPDATE: begin
        state_nxt = fravg_pkg::ST_AVG_DIV;
      end
      fravg_pkg::ST_AVG_DIV: begin
        if (div_last) state_nxt = fravg_pkg::ST_DONE;
      end
      fravg_pkg::ST_DONE: begin
        if (out_free) state_nxt = fravg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fravg_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    div_step    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      fravg_pkg::ST_IDLE:     in_ch.ready = 1'b1;
      fravg_pkg::ST_RATE_DIV: div_step    = 1'b1;
      fravg_pkg::ST_AVG_DIV:  div_step    = 1'b1;
      fravg_pkg::ST_DONE:     out_load    = out_free;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // One restoring division step: shift in the next dividend bit and subtract
  // the divisor when it fits.
  always_comb begin
    rem_shift = {rem_r, dvd_r[fravg_pkg::SUM_W-1]};
    q_bit     = (rem_shift >= {1'b0, dvs_r});
    rem_nxt   = q_bit ? fravg_pkg::TIME_W'(rem_shift - {1'b0, dvs_r})
                      : fravg_pkg::TIME_W'(rem_shift);
  end

  // Window update: rate from the finished quotient, then the running sum,
  // entry count and write slot.
  always_comb begin
    if (zero_int_r || (dvd_r > fravg_pkg::SUM_W'(fravg_pkg::RATE_MAX))) begin
      rate_val = fravg_pkg::RATE_W'(fravg_pkg::RATE_MAX);
    end else begin
      rate_val = dvd_r[fravg_pkg::RATE_W-1:0];
    end
    sum_nxt = sum_r - (win_full ? fravg_pkg::SUM_W'(rd_data_r) : '0)
            + fravg_pkg::SUM_W'(rate_val);
    cnt_nxt = win_full ? cnt_r : cnt_r + 1'b1;
    if (slot_r == fravg_pkg::SLOT_W'(fravg_pkg::HISTORY_DEPTH - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  // Integer part of the window mean, saturated.
  always_comb begin
    avg_full = dvd_r[fravg_pkg::SUM_W-1:fravg_pkg::FRAC_W];
    if (avg_full > (fravg_pkg::SUM_W - fravg_pkg::FRAC_W)'(fravg_pkg::AVG_MAX)) begin
      avg_val = fravg_pkg::AVG_W'(fravg_pkg::AVG_MAX);
    end else begin
      avg_val = avg_full[fravg_pkg::AVG_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fravg_pkg::ST_IDLE;
      last_time_r   <= '0;
      slot_r        <= '0;
      cnt_r         <= '0;
      sum_r         <= '0;
      width_hold_r  <= '0;
      height_hold_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        last_time_r <= in_ch.now_ms;
        if (!in_ch.frame_is_null) begin
          width_hold_r  <= in_ch.frame_width;
          height_hold_r <= in_ch.frame_height;
        end
      end
      if (state_r == fravg_pkg::ST_UPDATE) begin
        slot_r <= slot_nxt;
        cnt_r  <= cnt_nxt;
        sum_r  <= sum_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // History memory: read the oldest entry on accept, write the new rate back
  // in the update cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r <= hist_mem[slot_r];
    end
    if (state_r == fravg_pkg::ST_UPDATE) begin
      hist_mem[slot_r] <= rate_val;
    end
  end

  // Shared divider: the dividend register collects the quotient bits.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dvd_r      <= fravg_pkg::SUM_W'(fravg_pkg::RATE_NUM);
      dvs_r      <= interval;
      rem_r      <= '0;
      div_cnt_r  <= fravg_pkg::DIV_CNT_W'(fravg_pkg::SUM_W - 1);
      zero_int_r <= (interval == '0);
    end else if (state_r == fravg_pkg::ST_UPDATE) begin
      rate_r    <= rate_val;
      dvd_r     <= sum_nxt;
      dvs_r     <= fravg_pkg::TIME_W'(cnt_nxt);
      rem_r     <= '0;
      div_cnt_r <= fravg_pkg::DIV_CNT_W'(fravg_pkg::SUM_W - 1);
    end else if (div_step) begin
      dvd_r     <= {dvd_r[fravg_pkg::SUM_W-2:0], q_bit};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      fps_instant_r <= rate_r;
      fps_average_r <= avg_val;
      held_width_r  <= width_hold_r;
      held_height_r <= height_hold_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fps_instant = fps_instant_r;
  assign out_ch.fps_average = fps_average_r;
  assign out_ch.held_width  = held_width_r;
  assign out_ch.held_height = held_height_r;

  // The entry count never passes the window depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fravg_pkg::CNT_W'(fravg_pkg::HISTORY_DEPTH))
    else $error("entry count beyond window depth");

  // Until the window fills, the write slot tracks the entry count.
  a_slot_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    !win_full |-> (fravg_pkg::CNT_W'(slot_r) == cnt_r))
    else $error("write slot out of step with entry count");

  // The divider remainder stays below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (div_step && (dvs_r != '0)) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  // An accepted frame beat starts the rate division.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == fravg_pkg::ST_RATE_DIV))
    else $error("accepted beat did not start the rate division");

endmodule

// File: bench/frame_rate_moving_average_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate meter testbench
// Sends frame beats with chosen and random time stamps, predicts the
// instantaneous rate, the window mean and the held frame size of every beat,
// and compares each result beat with the oldest prediction. The run goes
// through phases with no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module frame_rate_moving_average_top_tb;

  localparam int LATENCY     = 2 * fravg_pkg::SUM_W + 3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BEATS = 420;
  localparam int PEND_DEPTH  = 64;

  typedef struct packed {
    logic [fravg_pkg::TIME_W-1:0] now_ms;
    logic                         is_null;
    logic [fravg_pkg::DIM_W-1:0]  width;
    logic [fravg_pkg::DIM_W-1:0]  height;
  } frame_beat_t;

  typedef struct packed {
    logic [fravg_pkg::RATE_W-1:0] fps_instant;
    logic [fravg_pkg::AVG_W-1:0]  fps_average;
    logic [fravg_pkg::DIM_W-1:0]  held_width;
    logic [fravg_pkg::DIM_W-1:0]  held_height;
  } rate_beat_t;

  logic clk;
  logic rst_n;

  fravg_in_if  frame_if ();
  fravg_out_if rate_if ();

  frame_rate_moving_average_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (frame_if),
    .out_ch (rate_if)
  );

  // Predicted meter state.
  logic [fravg_pkg::TIME_W-1:0] seen_last_ms;
  logic [fravg_pkg::RATE_W-1:0] window_rate [fravg_pkg::HISTORY_DEPTH];
  int unsigned                  window_slot;
  int unsigned                  window_fill;
  longint unsigned              window_total;
  logic [fravg_pkg::DIM_W-1:0]  hold_w;
  logic [fravg_pkg::DIM_W-1:0]  hold_h;

  // Predictions waiting for their result beat, oldest at pend_head.
  rate_beat_t  pending_rates [PEND_DEPTH];
  int unsigned pend_head = 0;
  int unsigned pend_tail = 0;

  logic [fravg_pkg::TIME_W-1:0] stamp_ms;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned frames_sent;
  int unsigned results_checked = 0;
  int unsigned full_window_frames;
  int unsigned saturated_frames;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Works out the result beat of one accepted frame and advances the state.
  function automatic rate_beat_t meter_predict(input frame_beat_t f);
    rate_beat_t                   r;
    logic [fravg_pkg::TIME_W-1:0] gap_ms;
    longint unsigned              rate;
    longint unsigned              mean;
    gap_ms = f.now_ms - seen_last_ms;
    if (gap_ms == '0) begin
      rate = 64'(fravg_pkg::RATE_MAX);
    end else begin
      rate = longint'(fravg_pkg::RATE_NUM) / longint'(gap_ms);
      if (rate > fravg_pkg::RATE_MAX) rate = 64'(fravg_pkg::RATE_MAX);
    end
    seen_last_ms = f.now_ms;
    if (window_fill >= fravg_pkg::HISTORY_DEPTH) begin
      window_total -= 64'(window_rate[window_slot]);
      full_window_frames++;
    end else begin
      window_fill++;
    end
    window_rate[window_slot] = rate[fravg_pkg::RATE_W-1:0];
    window_total += rate;
    window_slot = (window_slot + 1) % fravg_pkg::HISTORY_DEPTH;
    mean = (window_total / 64'(window_fill)) >> fravg_pkg::FRAC_W;
    if (mean > fravg_pkg::AVG_MAX) mean = 64'(fravg_pkg::AVG_MAX);
    if (!f.is_null) begin
      hold_w = f.width;
      hold_h = f.height;
    end
    if (rate == fravg_pkg::RATE_MAX) saturated_frames++;
    r.fps_instant = rate[fravg_pkg::RATE_W-1:0];
    r.fps_average = mean[fravg_pkg::AVG_W-1:0];
    r.held_width  = hold_w;
    r.held_height = hold_h;
    return r;
  endfunction

  // Sends one frame beat, with a random gap first, and records its prediction.
  task automatic send_frame(input frame_beat_t f);
    while ($urandom_range(99) < sender_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid         <= 1'b1;
    frame_if.now_ms        <= f.now_ms;
    frame_if.frame_is_null <= f.is_null;
    frame_if.frame_width   <= f.width;
    frame_if.frame_height  <= f.height;
    do @(posedge clk); while (!(frame_if.valid && frame_if.ready));
    pending_rates[pend_tail % PEND_DEPTH] = meter_predict(f);
    pend_tail++;
    frames_sent++;
  endtask

  // Sends a frame at an absolute time stamp.
  task automatic send_at(input logic [fravg_pkg::TIME_W-1:0] now_ms, input logic is_null,
                         input logic [fravg_pkg::DIM_W-1:0] w,
                         input logic [fravg_pkg::DIM_W-1:0] h);
    frame_beat_t f;
    f.now_ms  = now_ms;
    f.is_null = is_null;
    f.width   = w;
    f.height  = h;
    stamp_ms  = now_ms;
    send_frame(f);
  endtask

  // Sends a frame a given number of milliseconds after the previous one.
  task automatic send_after(input logic [fravg_pkg::TIME_W-1:0] gap_ms,
                            input logic is_null,
                            input logic [fravg_pkg::DIM_W-1:0] w,
                            input logic [fravg_pkg::DIM_W-1:0] h);
    send_at(stamp_ms + gap_ms, is_null, w, h);
  endtask

  // Compares one field of a result beat.
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    rate_beat_t want;
    if (rst_n && rate_if.valid === 1'b1 && rate_if.ready) begin
      if (pend_head == pend_tail) begin
        $display("%0t: result beat with none pending, actual %0d %0d %0d %0d", $time,
                 rate_if.fps_instant, rate_if.fps_average, rate_if.held_width,
                 rate_if.held_height);
        mismatch_count++;
      end else begin
        want = pending_rates[pend_head % PEND_DEPTH];
        pend_head++;
        check_field("fps_instant", 32'(want.fps_instant), 32'(rate_if.fps_instant));
        check_field("fps_average", 32'(want.fps_average), 32'(rate_if.fps_average));
        check_field("held_width", 32'(want.held_width), 32'(rate_if.held_width));
        check_field("held_height", 32'(want.held_height), 32'(rate_if.held_height));
        results_checked++;
      end
    end
    rate_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pend_tail - pend_head);
      $display("Mismatches found");
      $finish;
    end
  end

  // Extremes of the fields, zero gaps, timer wrap and null frames.
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // The first frame is measured from time zero; a null frame keeps the size.
    send_at(32'd0, 1'b1, 12'hFFF, 12'hFFF);
    send_after(32'd1, 1'b0, 12'hFFF, 12'hFFF);
    send_after(32'd0, 1'b0, 12'h000, 12'h000);
    send_after(32'd1000, 1'b0, 12'h001, 12'h800);
    send_after(32'd256001, 1'b0, 12'hAAA, 12'h555);
    send_after(32'd256000, 1'b1, 12'h123, 12'h456);
    send_after(32'd976, 1'b1, 12'h000, 12'hFFF);
    send_after(32'd2, 1'b0, 12'h555, 12'hAAA);
    send_after(32'd3, 1'b0, 12'h7FF, 12'h800);
    // The timer wraps past its top value.
    send_at(32'hFFFF_FFFA, 1'b0, 12'h800, 12'h7FF);
    send_after(32'd10, 1'b0, 12'h3C0, 12'h21C);
    send_after(32'hFFFF_FFFF, 1'b1, 12'h000, 12'h000);
    send_at(32'h8000_0000, 1'b0, 12'h780, 12'h438);
    send_at(32'h7FFF_FFFF, 1'b0, 12'h500, 12'h2D0);
    send_after(32'd33, 1'b1, 12'hFFF, 12'h000);
    send_after(32'd16, 1'b0, 12'h280, 12'h1E0);
    send_after(32'd17, 1'b0, 12'h140, 12'h0F0);
    send_after(32'd0, 1'b1, 12'h001, 12'h001);
    send_after(32'd0, 1'b0, 12'hFFE, 12'hFFE);
    send_after(32'd255, 1'b0, 12'h0A0, 12'h078);
  endtask

  // Random frames: mostly plausible frame gaps, some bursts, long gaps and jumps.
  task automatic run_random(input int unsigned beats);
    int unsigned                 pick;
    logic                        null_frame;
    logic [fravg_pkg::DIM_W-1:0] w;
    logic [fravg_pkg::DIM_W-1:0] h;
    repeat (beats) begin
      pick       = $urandom_range(99);
      null_frame = ($urandom_range(3) == 0);
      w          = fravg_pkg::DIM_W'($urandom_range(4095));
      h          = fravg_pkg::DIM_W'($urandom_range(4095));
      if (pick < 70) begin
        send_after($urandom_range(100, 1), null_frame, w, h);
      end else if (pick < 80) begin
        send_after($urandom_range(3, 0), null_frame, w, h);
      end else if (pick < 90) begin
        send_after($urandom_range(300000, 101), null_frame, w, h);
      end else begin
        send_at($urandom, null_frame, w, h);
      end
    end
  endtask

  task automatic test_no_idling();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(PHASE_BEATS);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct    = 50;
    receiver_stall_pct = 0;
    run_random(PHASE_BEATS);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 50;
    run_random(PHASE_BEATS);
  endtask

  task automatic test_both_idle();
    sender_idle_pct    = 25;
    receiver_stall_pct = 25;
    run_random(PHASE_BEATS);
  endtask

  // Main sequence.
  initial begin
    rst_n                  = 1'b0;
    frame_if.valid         = 1'b0;
    frame_if.now_ms        = '0;
    frame_if.frame_is_null = 1'b0;
    frame_if.frame_width   = '0;
    frame_if.frame_height  = '0;
    seen_last_ms           = '0;
    window_slot            = 0;
    window_fill            = 0;
    window_total           = 0;
    hold_w                 = '0;
    hold_h                 = '0;
    stamp_ms               = '0;
    sender_idle_pct        = 0;
    receiver_stall_pct     = 0;
    frames_sent            = 0;
    full_window_frames     = 0;
    saturated_frames       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    // Drain the remaining results and let the block settle.
    frame_if.valid <= 1'b0;
    while (pend_head != pend_tail) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d frame beats and checked %0d result beats.", frames_sent,
             results_checked);
    $display("%0d frames arrived with a full window, %0d with a saturated rate.",
             full_window_frames, saturated_frames);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
